// ===== rtl/ncrc_pkg.sv =====
// Shared types, constants and saturating Q16.48 helpers for the Newton root classifier.
// Used by ncrc_mul, ncrc_div and newton_cubic_root_classifier. No dependencies.
`timescale 1ns / 1ps

package ncrc_pkg;

   localparam int WORD_W = 64;
   localparam int WIDE_W = 128;
   localparam int FRAC_BITS = 48;
   localparam int QUO_STEPS = 176;

   typedef logic signed [WORD_W-1:0] q64_type;
   typedef logic [WORD_W-1:0] u64_type;
   typedef logic [WIDE_W-1:0] u128_type;

   // Configuration register indexes.
   localparam logic CSR_TOLERANCE = 1'b0;
   localparam logic CSR_STEP_LIMIT = 1'b1;

   localparam logic [31:0] TOL_RESET = 32'd281474977;
   localparam logic [7:0] LIMIT_RESET = 8'd20;

   localparam q64_type Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam q64_type Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam q64_type Q_ONE = q64_type'(64'd1 << FRAC_BITS);
   localparam q64_type Q_HALF = q64_type'(64'd1 << (FRAC_BITS - 1));

   // Multiplications the sequencer runs, in program order but for MOP_TT, which runs first.
   typedef enum logic [3:0] {
      MOP_XRXR, MOP_XIXI, MOP_XRXI, MOP_XRZ2R, MOP_XIZ2I, MOP_XRZ2I, MOP_XIZ2R,
      MOP_DRDR, MOP_DIDI, MOP_FRDR, MOP_FIDI, MOP_FIDR, MOP_FRDI,
      MOP_DRE2, MOP_DIM2, MOP_TT
   } mop_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_CHECK, ST_FINISH
   } state_type;

   // floor(sqrt(3) * 2^47), found bit by bit at elaboration.
   function automatic q64_type half_sqrt3();
      logic [127:0] target;
      logic [63:0] c;
      logic [63:0] t;
      target = 128'd3 << 94;
      c = '0;
      for (int b = 48; b >= 0; b--) begin
         t = c | (64'd1 << b);
         if (target >= ({64'd0, t} * {64'd0, t})) begin
            c = t;
         end
      end
      return q64_type'(c);
   endfunction

   localparam q64_type Q_H = half_sqrt3();

   function automatic q64_type sadd(input q64_type a, input q64_type b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? Q_MIN : Q_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic q64_type ssub(input q64_type a, input q64_type b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? Q_MIN : Q_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic u64_type mag64(input q64_type a);
      return a[WORD_W-1] ? u64_type'(-a) : u64_type'(a);
   endfunction

   function automatic q64_type from_mag(input logic neg, input u64_type m);
      if (m[WORD_W-1]) begin
         return neg ? Q_MIN : Q_MAX;
      end
      return neg ? -q64_type'(m) : q64_type'(m);
   endfunction

   // Rescale an exact product magnitude to Q16.48 with truncation and saturation.
   function automatic q64_type qfix(input u128_type p, input logic neg);
      u64_type m;
      m = (|p[WIDE_W-1:WIDE_W-16]) ? '1 : p[WIDE_W-17:FRAC_BITS];
      return from_mag(neg, m);
   endfunction

   function automatic q64_type root_re(input logic [1:0] k);
      case (k)
         2'd0: return Q_ONE;
         default: return -Q_HALF;
      endcase
   endfunction

   function automatic q64_type root_im(input logic [1:0] k);
      case (k)
         2'd0: return '0;
         2'd1: return Q_H;
         default: return -Q_H;
      endcase
   endfunction

   function automatic u64_type absdiff(input q64_type a, input q64_type b);
      return (a >= b) ? u64_type'(a - b) : u64_type'(b - a);
   endfunction

endpackage

// ===== rtl/ncrc_mul.sv =====
// Shared 64 x 64 unsigned multiplier built from one 32 x 32 multiplier.
// Depends on ncrc_pkg for widths.
`timescale 1ns / 1ps

module ncrc_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ncrc_pkg::u64_type op_a,
   input  ncrc_pkg::u64_type op_b,
   output logic              done,
   output ncrc_pkg::u128_type prod
);

   logic [2:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   ncrc_pkg::u64_type a_ff, a_in, b_ff, b_in;
   logic [63:0] p_ff, p_in;
   logic [6:0] sh_ff, sh_in;
   ncrc_pkg::u128_type acc_ff, acc_in;
   logic [31:0] ha, hb;

   // Piece k: a0*b0, a0*b1, a1*b0, a1*b1.
   always_comb begin
      ha = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      hb = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      sh_in = sh_ff;
      acc_in = acc_ff;
      if (start) begin
         a_in = op_a;
         b_in = op_b;
         cnt_in = '0;
         busy_in = 1'b1;
         acc_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            p_in = {32'd0, ha} * {32'd0, hb};
            sh_in = 7'(cnt_ff[0] + cnt_ff[1]) << 5;
         end
         if (cnt_ff != 3'd0) begin
            acc_in = acc_ff + ({64'd0, p_ff} << sh_ff);
         end
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
      sh_ff <= sh_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== rtl/ncrc_div.sv =====
// Restoring divider, one quotient bit a cycle: floor(num * 2^48 / den), saturated to 64 bits.
// Depends on ncrc_pkg for widths and the step count.
`timescale 1ns / 1ps

module ncrc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ncrc_pkg::u128_type num,
   input  ncrc_pkg::u128_type den,
   output logic               done,
   output ncrc_pkg::u64_type  quo
);

   logic [7:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic over_ff, over_in;
   ncrc_pkg::u128_type n_ff, n_in, d_ff, d_in, r_ff, r_in, r2;
   ncrc_pkg::u64_type q_ff, q_in;
   logic take;

   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      over_in = over_ff;
      n_in = n_ff;
      d_in = d_ff;
      r_in = r_ff;
      q_in = q_ff;
      r2 = {r_ff[126:0], n_ff[127]};
      // The bit shifted out of the remainder counts as a carry above den.
      take = r_ff[127] || (r2 >= d_ff);
      if (start) begin
         n_in = num;
         d_in = den;
         r_in = '0;
         q_in = '0;
         over_in = 1'b0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[126:0], 1'b0};
         r_in = take ? r2 - d_ff : r2;
         over_in = over_ff | q_ff[63];
         q_in = {q_ff[62:0], take};
         cnt_in = cnt_ff + 8'd1;
         if (cnt_ff == 8'(ncrc_pkg::QUO_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      over_ff <= over_in;
      n_ff <= n_in;
      d_ff <= d_in;
      r_ff <= r_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quo = over_ff ? '1 : q_ff;

endmodule

// ===== rtl/newton_cubic_root_classifier.sv =====
// Newton root classifier for z^3 - 1: sequencer around one shared multiplier and one divider.
// Depends on ncrc_pkg, ncrc_mul and ncrc_div.
//
//   channel  | dir | payload
//   req_     | in  | tdata[31:0] point_re, tdata[63:32] point_im (Q4.28)
//   rsp_     | out | tdata[1:0] root_class, tdata[7:2] zero
//   csr_     | in  | index 0 tolerance, 1 step_limit[7:0]
//
// One Newton step runs 13 multiplies on the shared 32 x 32 multiplier, two divisions
// and up to three root checks. A root that passes the box test adds two multiplies;
// a zero derivative skips the last four multiplies and the divisions. An item runs up
// to step_limit steps after one multiply that squares the tolerance; a limit of zero
// returns class 0 with no step. The block takes a new item only when idle; a result not
// yet taken stalls the next item's last cycle. Reset is synchronous; no clearing pass is
// needed.
`timescale 1ns / 1ps

module newton_cubic_root_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_re [31:0], point_im [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // root_class [1:0], zero fill [7:2]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   ncrc_pkg::state_type state_ff, state_in;
   ncrc_pkg::mop_type mop_ff, mop_in;
   logic [31:0] tol_ff;
   logic [7:0] limit_ff, steps_ff, steps_in;
   logic [1:0] rk_ff, rk_in, cls_ff, cls_in;
   logic divsel_ff, divsel_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_cls_ff, rsp_cls_in;
   ncrc_pkg::q64_type xr_ff, xr_in, xi_ff, xi_in, z2r_ff, z2r_in, z2i_ff, z2i_in;
   ncrc_pkg::q64_type t0_ff, t0_in, fr_ff, fr_in, fi_ff, fi_in, dr_ff, dr_in, di_ff, di_in;
   ncrc_pkg::q64_type qr_ff, qr_in;
   ncrc_pkg::u64_type tt_ff, tt_in;
   ncrc_pkg::u128_type w0_ff, w0_in, den_ff, den_in, numre_ff, numre_in, numim_ff, numim_in;
   logic n0_ff, n0_in, nre_ff, nre_in, nim_ff, nim_in;

   ncrc_pkg::q64_type sa, sb;
   logic sa_mag;
   ncrc_pkg::u64_type op_a, op_b, dre, dim;
   logic neg, mul_start, mul_done, div_start, div_done;
   ncrc_pkg::u128_type prod, den_sum, div_num;
   ncrc_pkg::u64_type quo;
   ncrc_pkg::q64_type qv, sq;
   logic [64:0] dist_sum;
   logic next_root, c_neg, c_n2;
   ncrc_pkg::u128_type c_mag;

   ncrc_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(op_a), .op_b(op_b), .done(mul_done), .prod(prod)
   );

   ncrc_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(den_ff), .done(div_done), .quo(quo)
   );

   assign dre = ncrc_pkg::absdiff(xr_ff, ncrc_pkg::root_re(rk_ff));
   assign dim = ncrc_pkg::absdiff(xi_ff, ncrc_pkg::root_im(rk_ff));
   assign div_num = divsel_ff ? numim_ff : numre_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      sa = '0;
      sb = '0;
      sa_mag = 1'b0;
      op_a = '0;
      op_b = '0;
      unique case (mop_ff)
         ncrc_pkg::MOP_XRXR:  begin sa = xr_ff; sb = xr_ff; end
         ncrc_pkg::MOP_XIXI:  begin sa = xi_ff; sb = xi_ff; end
         ncrc_pkg::MOP_XRXI:  begin sa = xr_ff; sb = xi_ff; end
         ncrc_pkg::MOP_XRZ2R: begin sa = xr_ff; sb = z2r_ff; end
         ncrc_pkg::MOP_XIZ2I: begin sa = xi_ff; sb = z2i_ff; end
         ncrc_pkg::MOP_XRZ2I: begin sa = xr_ff; sb = z2i_ff; end
         ncrc_pkg::MOP_XIZ2R: begin sa = xi_ff; sb = z2r_ff; end
         ncrc_pkg::MOP_DRDR:  begin sa = dr_ff; sb = dr_ff; end
         ncrc_pkg::MOP_DIDI:  begin sa = di_ff; sb = di_ff; end
         ncrc_pkg::MOP_FRDR:  begin sa = fr_ff; sb = dr_ff; end
         ncrc_pkg::MOP_FIDI:  begin sa = fi_ff; sb = di_ff; end
         ncrc_pkg::MOP_FIDR:  begin sa = fi_ff; sb = dr_ff; end
         ncrc_pkg::MOP_FRDI:  begin sa = fr_ff; sb = di_ff; end
         ncrc_pkg::MOP_DRE2:  begin sa_mag = 1'b1; op_a = dre; op_b = dre; end
         ncrc_pkg::MOP_DIM2:  begin sa_mag = 1'b1; op_a = dim; op_b = dim; end
         ncrc_pkg::MOP_TT:    begin sa_mag = 1'b1; op_a = {32'd0, tol_ff}; op_b = op_a; end
         default: ;
      endcase
      if (!sa_mag) begin
         op_a = ncrc_pkg::mag64(sa);
         op_b = ncrc_pkg::mag64(sb);
      end
      neg = sa[63] ^ sb[63];
   end

   always_comb begin
      state_in = state_ff;
      mop_in = mop_ff;
      steps_in = steps_ff;
      rk_in = rk_ff;
      cls_in = cls_ff;
      divsel_in = divsel_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_cls_in = rsp_cls_ff;
      xr_in = xr_ff; xi_in = xi_ff; z2r_in = z2r_ff; z2i_in = z2i_ff;
      t0_in = t0_ff; fr_in = fr_ff; fi_in = fi_ff; dr_in = dr_ff; di_in = di_ff;
      qr_in = qr_ff; tt_in = tt_ff; w0_in = w0_ff; den_in = den_ff;
      numre_in = numre_ff; numim_in = numim_ff;
      n0_in = n0_ff; nre_in = nre_ff; nim_in = nim_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      next_root = 1'b0;
      qv = ncrc_pkg::qfix(prod, neg);
      sq = ncrc_pkg::ssub(t0_ff, qv);
      den_sum = w0_ff + prod;
      dist_sum = {1'b0, w0_ff[63:0]} + {1'b0, prod[63:0]};
      // Signed sum of the held product and the fresh one (negated for MOP_FRDI), as sign and magnitude.
      c_n2 = (mop_ff == ncrc_pkg::MOP_FRDI) ? ~neg : neg;
      if (n0_ff == c_n2) begin
         c_neg = n0_ff;
         c_mag = w0_ff + prod;
      end else if (w0_ff >= prod) begin
         c_neg = n0_ff;
         c_mag = w0_ff - prod;
      end else begin
         c_neg = c_n2;
         c_mag = prod - w0_ff;
      end

      unique case (state_ff)
         ncrc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               xr_in = {{12{req_tdata[31]}}, req_tdata[31:0], 20'd0};
               xi_in = {{12{req_tdata[63]}}, req_tdata[63:32], 20'd0};
               steps_in = '0;
               cls_in = '0;
               mop_in = ncrc_pkg::MOP_TT;
               state_in = (limit_ff == 8'd0) ? ncrc_pkg::ST_FINISH : ncrc_pkg::ST_MUL_GO;
            end
         end
         ncrc_pkg::ST_MUL_GO: begin
            mul_start = 1'b1;
            state_in = ncrc_pkg::ST_MUL_WAIT;
         end
         ncrc_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ncrc_pkg::ST_MUL_GO;
               mop_in = ncrc_pkg::mop_type'(mop_ff + 4'd1);
               unique case (mop_ff)
                  ncrc_pkg::MOP_TT: begin
                     tt_in = prod[63:0];
                     mop_in = ncrc_pkg::MOP_XRXR;
                  end
                  ncrc_pkg::MOP_XRXR, ncrc_pkg::MOP_XRZ2I: t0_in = qv;
                  ncrc_pkg::MOP_XIXI: z2r_in = sq;
                  ncrc_pkg::MOP_XRXI: z2i_in = ncrc_pkg::sadd(qv, qv);
                  ncrc_pkg::MOP_XRZ2R: begin
                     t0_in = qv;
                     dr_in = ncrc_pkg::sadd(ncrc_pkg::sadd(z2r_ff, z2r_ff), z2r_ff);
                     di_in = ncrc_pkg::sadd(ncrc_pkg::sadd(z2i_ff, z2i_ff), z2i_ff);
                  end
                  ncrc_pkg::MOP_XIZ2I: fr_in = ncrc_pkg::sadd(sq, -ncrc_pkg::Q_ONE);
                  ncrc_pkg::MOP_XIZ2R: fi_in = ncrc_pkg::sadd(t0_ff, qv);
                  ncrc_pkg::MOP_DRDR, ncrc_pkg::MOP_DRE2: w0_in = prod;
                  ncrc_pkg::MOP_DIDI: begin
                     den_in = den_sum;
                     // A zero derivative leaves the iterate where it is.
                     if (den_sum == '0) begin
                        rk_in = '0;
                        state_in = ncrc_pkg::ST_CHECK;
                     end
                  end
                  ncrc_pkg::MOP_FRDR, ncrc_pkg::MOP_FIDR: begin
                     w0_in = prod;
                     n0_in = neg;
                  end
                  ncrc_pkg::MOP_FIDI: begin
                     numre_in = c_mag;
                     nre_in = c_neg;
                  end
                  ncrc_pkg::MOP_FRDI: begin
                     numim_in = c_mag;
                     nim_in = c_neg;
                     divsel_in = 1'b0;
                     state_in = ncrc_pkg::ST_DIV_GO;
                  end
                  ncrc_pkg::MOP_DIM2: begin
                     if (dist_sum <= {1'b0, tt_ff}) begin
                        cls_in = rk_ff + 2'd1;
                        state_in = ncrc_pkg::ST_FINISH;
                     end else begin
                        next_root = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ncrc_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in = ncrc_pkg::ST_DIV_WAIT;
         end
         ncrc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (!divsel_ff) begin
                  qr_in = ncrc_pkg::from_mag(nre_ff, quo);
                  divsel_in = 1'b1;
                  state_in = ncrc_pkg::ST_DIV_GO;
               end else begin
                  xr_in = ncrc_pkg::ssub(xr_ff, qr_ff);
                  xi_in = ncrc_pkg::ssub(xi_ff, ncrc_pkg::from_mag(nim_ff, quo));
                  rk_in = '0;
                  state_in = ncrc_pkg::ST_CHECK;
               end
            end
         end
         ncrc_pkg::ST_CHECK: begin
            if ((dre > {32'd0, tol_ff}) || (dim > {32'd0, tol_ff})) begin
               next_root = 1'b1;
            end else begin
               mop_in = ncrc_pkg::MOP_DRE2;
               state_in = ncrc_pkg::ST_MUL_GO;
            end
         end
         ncrc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_cls_in = cls_ff;
               state_in = ncrc_pkg::ST_IDLE;
            end
         end
         default: state_in = ncrc_pkg::ST_IDLE;
      endcase

      // Move on to the next root, or end the step after the third one.
      if (next_root) begin
         if (rk_ff != 2'd2) begin
            rk_in = rk_ff + 2'd1;
            state_in = ncrc_pkg::ST_CHECK;
         end else if (steps_ff + 8'd1 == limit_ff) begin
            cls_in = '0;
            state_in = ncrc_pkg::ST_FINISH;
         end else begin
            steps_in = steps_ff + 8'd1;
            mop_in = ncrc_pkg::MOP_XRXR;
            state_in = ncrc_pkg::ST_MUL_GO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ncrc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff <= ncrc_pkg::TOL_RESET;
         limit_ff <= ncrc_pkg::LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               ncrc_pkg::CSR_TOLERANCE: tol_ff <= csr_data;
               ncrc_pkg::CSR_STEP_LIMIT: limit_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
      mop_ff <= mop_in;
      steps_ff <= steps_in;
      rk_ff <= rk_in;
      cls_ff <= cls_in;
      divsel_ff <= divsel_in;
      rsp_cls_ff <= rsp_cls_in;
      xr_ff <= xr_in; xi_ff <= xi_in; z2r_ff <= z2r_in; z2i_ff <= z2i_in;
      t0_ff <= t0_in; fr_ff <= fr_in; fi_ff <= fi_in; dr_ff <= dr_in; di_ff <= di_in;
      qr_ff <= qr_in; tt_ff <= tt_in; w0_ff <= w0_in; den_ff <= den_in;
      numre_ff <= numre_in; numim_ff <= numim_in;
      n0_ff <= n0_in; nre_ff <= nre_in; nim_ff <= nim_in;
   end

   assign req_tready = (state_ff == ncrc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, rsp_cls_ff};
   assign csr_ready = 1'b1;

endmodule
